FILE: rtl/core/sclp_pkg.sv
// Shared types, constants and configuration codes of the serial command line parser.
package sclp_pkg;

    // Default values of the top-level parameters.
    localparam int LINE_BYTES_DEF  = 64;
    localparam int CODE_DIGITS_DEF = 2;
    localparam int ID_DIGITS_DEF   = 4;
    localparam int TABLE_SLOTS_DEF = 8;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Line terminator.
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // Register reset values.
    localparam logic [7:0]  START_CHAR_RST   = 8'h24;
    localparam logic [7:0]  SEPARATOR_RST    = 8'h3A;
    localparam logic [15:0] TIMEOUT_RST      = 16'd100;

    // Saturation limit of the elapsed tick counter.
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_CHAR      = 3'd0,
        REG_ID_SEPARATOR    = 3'd1,
        REG_PARAM_SEPARATOR = 3'd2,
        REG_TIMEOUT_TICKS   = 3'd3,
        REG_COMMAND_CODES   = 3'd4,
        REG_COMMAND_COUNT   = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_UNDEF  = 2'd2,
        ST_SERIAL = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  start_char;
        logic [7:0]  id_separator;
        logic [7:0]  param_separator;
        logic [15:0] timeout_ticks;
        logic [63:0] command_codes;
        logic [3:0]  command_count;
    } cfg_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  command_slot;
        logic [7:0]  command_code;
        logic [15:0] request_id;
        logic [7:0]  param_byte;
        logic        param_valid;
        logic        last;
    } res_t;

endpackage

FILE: rtl/core/sclp_cfg.sv
// Configuration register file of the serial command line parser.
module sclp_cfg
    import sclp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_CHAR:      cfg_next.start_char      = cfg_data[7:0];
                REG_ID_SEPARATOR:    cfg_next.id_separator    = cfg_data[7:0];
                REG_PARAM_SEPARATOR: cfg_next.param_separator = cfg_data[7:0];
                REG_TIMEOUT_TICKS:   cfg_next.timeout_ticks   = cfg_data[15:0];
                REG_COMMAND_CODES:   cfg_next.command_codes   = cfg_data;
                REG_COMMAND_COUNT:   cfg_next.command_count   = cfg_data[3:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_char      <= START_CHAR_RST;
            cfg_reg.id_separator    <= SEPARATOR_RST;
            cfg_reg.param_separator <= SEPARATOR_RST;
            cfg_reg.timeout_ticks   <= TIMEOUT_RST;
            cfg_reg.command_codes   <= '0;
            cfg_reg.command_count   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/sclp_mem.sv
// Line buffer memory: one write port and one read port with registered read data.
module sclp_mem
    import sclp_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    localparam int AW = $clog2(LINE_BYTES)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [LINE_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds its value until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/sclp_seq.sv
// Line sequencer: byte capture, timeout, header check, table match and parameter streaming.
module sclp_seq
    import sclp_pkg::*;
#(
    parameter int LINE_BYTES  = LINE_BYTES_DEF,
    parameter int CODE_DIGITS = CODE_DIGITS_DEF,
    parameter int ID_DIGITS   = ID_DIGITS_DEF,
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    localparam int AW = $clog2(LINE_BYTES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          item_valid,
    output logic          item_ready,
    input  item_t         item,
    output logic          result_valid,
    input  logic          result_ready,
    output res_t          result,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    input  logic [7:0]    mem_rdata
);

    localparam int FW        = $clog2(LINE_BYTES + 1);
    localparam int SEP1_POS  = CODE_DIGITS + 1;
    localparam int SEP2_POS  = CODE_DIGITS + ID_DIGITS + 2;
    localparam int PARAM_POS = SEP2_POS + 1;

    typedef enum logic [4:0] {
        S_RX    = 5'b00001,
        S_HDR   = 5'b00010,
        S_MATCH = 5'b00100,
        S_PREQ  = 5'b01000,
        S_PDAT  = 5'b10000
    } seq_state_t;

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = '0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b1, c[3:0]};
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                r = {1'b1, 4'(c - 8'h57)};
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                r = {1'b1, 4'(c - 8'h37)};
            end
            return r;
        end
    endfunction

    seq_state_t  state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic        active_reg, active_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic [FW-1:0] pos_reg, pos_next;
    logic [FW-1:0] rpos_reg, rpos_next;
    logic        rvld_reg, rvld_next;
    logic        rin_reg, rin_next;
    logic        fmt_ok_reg, fmt_ok_next;
    logic        code_stop_reg, code_stop_next;
    logic        id_stop_reg, id_stop_next;
    logic        cur_have_reg, cur_have_next;
    logic        out_vld_reg, out_vld_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] id_reg, id_next;
    logic [2:0]  slot_reg, slot_next;
    logic [7:0]  cur_reg, cur_next;
    res_t        out_reg;

    logic        out_free;
    logic        acc;
    logic        out_load;
    res_t        out_val;
    logic        line_end;
    logic [16:0] elapsed_inc;
    logic [7:0]  rbyte;
    logic [4:0]  hx;
    logic [3:0]  slot_cnt;
    logic        hit;
    logic [2:0]  hit_slot;
    logic [FW-1:0] stop_pos;
    logic        pvalid;

    assign out_free   = !out_vld_reg || result_ready;
    assign item_ready = (state_reg == S_RX) && out_free;
    assign acc        = item_valid && item_ready;

    // Bytes beyond the stored part of the line read as zero.
    assign rbyte = rin_reg ? mem_rdata : 8'h00;
    assign hx    = hex_digit(rbyte);

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 17'd1;

    // Command table lookup; the lowest matching slot wins.
    always_comb
    begin
        slot_cnt = (cfg.command_count > 4'(TABLE_SLOTS)) ? 4'(TABLE_SLOTS)
                                                          : cfg.command_count;
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (4'(i) < slot_cnt && cfg.command_codes[8*i +: 8] == code_reg)
            begin
                hit      = 1'b1;
                hit_slot = 3'(i);
            end
        end
    end

    // Parameters end before the newline or at the first zero byte.
    assign stop_pos = fill_reg - FW'(1);
    assign pvalid   = (pos_reg < stop_pos) && (mem_rdata != 8'h00);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        active_next    = active_reg;
        elapsed_next   = elapsed_reg;
        pos_next       = pos_reg;
        rpos_next      = rpos_reg;
        rvld_next      = 1'b0;
        rin_next       = rin_reg;
        fmt_ok_next    = fmt_ok_reg;
        code_stop_next = code_stop_reg;
        id_stop_next   = id_stop_reg;
        cur_have_next  = cur_have_reg;
        code_next      = code_reg;
        id_next        = id_reg;
        slot_next      = slot_reg;
        cur_next       = cur_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_reg[AW-1:0];
        mem_wdata      = item.rx_byte;
        mem_re         = 1'b0;
        mem_raddr      = pos_reg[AW-1:0];
        out_load       = 1'b0;
        out_val        = '0;
        line_end       = 1'b0;

        unique case (state_reg)
            S_RX:
            begin
                if (acc && item.action)
                begin
                    if (active_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc > {1'b0, cfg.timeout_ticks})
                        begin
                            out_load       = 1'b1;
                            out_val.status = ST_SERIAL;
                            out_val.last   = 1'b1;
                            line_end       = 1'b1;
                        end
                    end
                end
                else if (acc)
                begin
                    active_next = 1'b1;
                    mem_we      = 1'b1;
                    fill_next   = fill_reg + FW'(1);
                    if (item.rx_byte == NEWLINE_BYTE)
                    begin
                        state_next     = S_HDR;
                        pos_next       = '0;
                        fmt_ok_next    = 1'b1;
                        code_stop_next = 1'b0;
                        id_stop_next   = 1'b0;
                        code_next      = '0;
                        id_next        = '0;
                    end
                    else if (fill_reg == FW'(LINE_BYTES - 1))
                    begin
                        out_load       = 1'b1;
                        out_val.status = ST_SERIAL;
                        out_val.last   = 1'b1;
                        line_end       = 1'b1;
                    end
                end
            end

            S_HDR:
            begin
                if (pos_reg <= FW'(SEP2_POS))
                begin
                    mem_re    = 1'b1;
                    pos_next  = pos_reg + FW'(1);
                    rpos_next = pos_reg;
                    rvld_next = 1'b1;
                    rin_next  = pos_reg < fill_reg;
                end
                if (rvld_reg)
                begin
                    priority if (rpos_reg == '0)
                    begin
                        fmt_ok_next = fmt_ok_reg && (rbyte == cfg.start_char);
                    end
                    else if (rpos_reg <= FW'(CODE_DIGITS))
                    begin
                        if (!code_stop_reg)
                        begin
                            if (hx[4])
                            begin
                                code_next = {code_reg[3:0], hx[3:0]};
                            end
                            else
                            begin
                                code_stop_next = 1'b1;
                            end
                        end
                    end
                    else if (rpos_reg == FW'(SEP1_POS))
                    begin
                        fmt_ok_next = fmt_ok_reg && (rbyte == cfg.id_separator);
                    end
                    else if (rpos_reg < FW'(SEP2_POS))
                    begin
                        if (!id_stop_reg)
                        begin
                            if (hx[4])
                            begin
                                id_next = {id_reg[11:0], hx[3:0]};
                            end
                            else
                            begin
                                id_stop_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        fmt_ok_next = fmt_ok_reg && (rbyte == cfg.param_separator);
                        state_next  = S_MATCH;
                    end
                end
            end

            S_MATCH:
            begin
                if (!fmt_ok_reg)
                begin
                    if (out_free)
                    begin
                        out_load       = 1'b1;
                        out_val.status = ST_FORMAT;
                        out_val.last   = 1'b1;
                        line_end       = 1'b1;
                        state_next     = S_RX;
                    end
                end
                else if (!hit)
                begin
                    if (out_free)
                    begin
                        out_load             = 1'b1;
                        out_val.status       = ST_UNDEF;
                        out_val.command_code = code_reg;
                        out_val.request_id   = id_reg;
                        out_val.last         = 1'b1;
                        line_end             = 1'b1;
                        state_next           = S_RX;
                    end
                end
                else
                begin
                    slot_next     = hit_slot;
                    cur_have_next = 1'b0;
                    pos_next      = FW'(PARAM_POS);
                    state_next    = S_PREQ;
                end
            end

            S_PREQ:
            begin
                mem_re     = 1'b1;
                state_next = S_PDAT;
            end

            S_PDAT:
            begin
                out_val.status       = ST_OK;
                out_val.command_slot = slot_reg;
                out_val.command_code = code_reg;
                out_val.request_id   = id_reg;
                if (!cur_have_reg)
                begin
                    if (pvalid)
                    begin
                        cur_next      = mem_rdata;
                        cur_have_next = 1'b1;
                        pos_next      = pos_reg + FW'(1);
                        state_next    = S_PREQ;
                    end
                    else if (out_free)
                    begin
                        out_load     = 1'b1;
                        out_val.last = 1'b1;
                        line_end     = 1'b1;
                        state_next   = S_RX;
                    end
                end
                else if (out_free)
                begin
                    // The byte held back goes out once we know whether another follows.
                    out_load            = 1'b1;
                    out_val.param_byte  = cur_reg;
                    out_val.param_valid = 1'b1;
                    out_val.last        = !pvalid;
                    if (pvalid)
                    begin
                        cur_next   = mem_rdata;
                        pos_next   = pos_reg + FW'(1);
                        state_next = S_PREQ;
                    end
                    else
                    begin
                        line_end   = 1'b1;
                        state_next = S_RX;
                    end
                end
            end

            default:
            begin
                state_next = S_RX;
            end
        endcase

        if (line_end)
        begin
            fill_next    = '0;
            active_next  = 1'b0;
            elapsed_next = '0;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RX;
            fill_reg      <= '0;
            active_reg    <= 1'b0;
            elapsed_reg   <= '0;
            pos_reg       <= '0;
            rpos_reg      <= '0;
            rvld_reg      <= 1'b0;
            rin_reg       <= 1'b0;
            fmt_ok_reg    <= 1'b0;
            code_stop_reg <= 1'b0;
            id_stop_reg   <= 1'b0;
            cur_have_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            active_reg    <= active_next;
            elapsed_reg   <= elapsed_next;
            pos_reg       <= pos_next;
            rpos_reg      <= rpos_next;
            rvld_reg      <= rvld_next;
            rin_reg       <= rin_next;
            fmt_ok_reg    <= fmt_ok_next;
            code_stop_reg <= code_stop_next;
            id_stop_reg   <= id_stop_next;
            cur_have_reg  <= cur_have_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        id_reg   <= id_next;
        slot_reg <= slot_next;
        cur_reg  <= cur_next;
        if (out_load)
        begin
            out_reg <= out_val;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule

FILE: rtl/core/serial_command_line_parser_top.sv
// Top level of the serial command line parser.
//
// The parser takes one transaction per cycle on the item channel while a line
// is being collected and the output register is free: each byte is written
// to the line memory at the fill position and each millisecond tick advances
// the timeout count. A timeout or a buffer that fills without a newline ends
// the line at once with a single serial-error result. When the newline
// arrives the item channel closes and the line is finished from the single
// read port of the line memory: the header (start character, code digits,
// separator, id digits, separator) is read back one byte a cycle, then the
// code is matched against the command table, then each parameter byte is
// read and handed to the output register, which waits while the result
// channel stalls. The memory is never cleared; the fill count marks which
// entries belong to the current line and the rest read as zero, so there is
// no clearing pass after reset. Results sit in an output register, so the
// next byte is taken in the same cycle that the last result of a line is
// taken. Configuration writes take effect at once and must only be made
// while no line is being finished.
module serial_command_line_parser_top
    import sclp_pkg::*;
#(
    parameter int LINE_BYTES  = LINE_BYTES_DEF,
    parameter int CODE_DIGITS = CODE_DIGITS_DEF,
    parameter int ID_DIGITS   = ID_DIGITS_DEF,
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output res_t                  result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(LINE_BYTES);

    cfg_t          cfg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    // Configuration registers.
    sclp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Line buffer memory.
    sclp_mem #(
        .LINE_BYTES (LINE_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer that collects, checks and streams each line.
    sclp_seq #(
        .LINE_BYTES  (LINE_BYTES),
        .CODE_DIGITS (CODE_DIGITS),
        .ID_DIGITS   (ID_DIGITS),
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

endmodule

FILE: rtl/core/sclp_chk.sv
// Port checker of the serial command line parser and its bind to the top level.
module sclp_chk
    import sclp_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  item_valid,
    input logic  item_ready,
    input item_t item,
    input logic  result_valid,
    input logic  result_ready,
    input res_t  result
);

    // A stalled result transaction keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Every result that carries no parameter byte closes its line.
    a_no_param_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.param_valid |-> result.last)
        else $error("result without parameter byte is not last");

    // Error results carry no slot and no parameter byte.
    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |->
            result.command_slot == 3'd0 && !result.param_valid && result.param_byte == 8'h00)
        else $error("error result carries slot or parameter");

    // Format and serial errors carry no decoded code or id.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_FORMAT || result.status == ST_SERIAL) |->
            result.command_code == 8'h00 && result.request_id == 16'h0000)
        else $error("error result carries decoded fields");

endmodule

bind serial_command_line_parser_top sclp_chk u_sclp_chk (.*);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the serial command line parser.
`timescale 1ns / 1ps

module tb_top;
    import sclp_pkg::*;

    // Line geometry, taken from the defaults that the block is built with.
    localparam int LINE_BYTES    = LINE_BYTES_DEF;
    localparam int CODE_DIGITS   = CODE_DIGITS_DEF;
    localparam int ID_DIGITS     = ID_DIGITS_DEF;
    localparam int TABLE_SLOTS   = TABLE_SLOTS_DEF;
    localparam int ID_SEP_POS    = CODE_DIGITS + 1;
    localparam int PARAM_SEP_POS = CODE_DIGITS + ID_DIGITS + 2;
    localparam int PARAM_POS     = CODE_DIGITS + ID_DIGITS + 3;

    // Kinds of input transaction.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Register index that maps to no register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Marks a character that is not a hex digit.
    localparam logic [4:0] NOT_HEX = 5'd16;

    // Quiet cycles before a register write; ample once every due reply has come out.
    localparam int SETTLE_CYCLES = 40;

    // The receiver's long hold-off, started once enough replies have passed.
    localparam int HOLD_AFTER  = 20;
    localparam int HOLD_CYCLES = 400;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    res_t                  result;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    serial_command_line_parser_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Stimulus queue, filled by the sequence below and emptied by the driver.
    item_t items_to_send[$];
    // Replies that the parser owes, oldest first.
    res_t  replies_due[$];

    // Our own copy of the configuration and of the line being collected.
    cfg_t        parser_cfg;
    logic [7:0]  line_bytes [LINE_BYTES];
    int          line_fill;
    logic        line_open;
    logic [16:0] line_ticks;

    int  queued_count   = 0;
    int  accepted_count = 0;
    int  useful_items   = 0;
    int  replies_seen   = 0;
    int  mismatch_count = 0;
    int  send_gap       = 0;
    int  recv_gap       = 0;
    int  hold_left      = 0;
    bit  long_hold_done = 1'b0;
    bit  gaps_on        = 1'b1;
    int  tick_pct       = 0;
    // Set at each rising edge when the item channel completed a transaction.
    logic item_taken    = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Parser prediction.
    // ------------------------------------------------------------------

    function automatic logic [7:0] byte_at(input int pos);
        return (pos < LINE_BYTES) ? line_bytes[pos] : 8'h00;
    endfunction

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return {1'b0, c[3:0] + 4'd9};
        return NOT_HEX;
    endfunction

    // Digits are read until the first byte that is not hex.
    function automatic logic [15:0] decode_hex(input int pos, input int digits);
        logic [15:0] value;
        logic [4:0]  d;
        value = '0;
        for (int i = 0; i < digits; i++)
        begin
            d = hex_nibble(byte_at(pos + i));
            if (d == NOT_HEX) break;
            value = {value[11:0], d[3:0]};
        end
        return value;
    endfunction

    task automatic clear_line();
        foreach (line_bytes[i]) line_bytes[i] = 8'h00;
        line_fill  = 0;
        line_open  = 1'b0;
        line_ticks = '0;
    endtask

    // A reply that carries nothing but its status.
    task automatic owe_status(input status_t st);
        res_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        replies_due.push_back(r);
    endtask

    task automatic owe_line_replies();
        res_t        r;
        logic [15:0] raw;
        logic [7:0]  code;
        logic [15:0] id;
        int          slots, stop, p;
        bit          found;
        if (byte_at(0) != parser_cfg.start_char ||
            byte_at(ID_SEP_POS) != parser_cfg.id_separator ||
            byte_at(PARAM_SEP_POS) != parser_cfg.param_separator)
        begin
            owe_status(ST_FORMAT);
            return;
        end
        raw  = decode_hex(1, CODE_DIGITS);
        code = raw[7:0];
        id   = decode_hex(ID_SEP_POS + 1, ID_DIGITS);
        r    = '0;
        r.command_code = code;
        r.request_id   = id;
        r.last         = 1'b1;
        // A count above the table size means the whole table; lowest slot wins.
        slots = (parser_cfg.command_count > TABLE_SLOTS) ? TABLE_SLOTS
                                                         : parser_cfg.command_count;
        found = 1'b0;
        for (int i = 0; i < slots; i++)
        begin
            if (parser_cfg.command_codes[8*i +: 8] == code)
            begin
                r.command_slot = i;
                found = 1'b1;
                break;
            end
        end
        if (!found)
        begin
            r.status = ST_UNDEF;
            replies_due.push_back(r);
            return;
        end
        r.status = ST_OK;
        // Parameters run up to the newline, or to the first zero byte.
        stop = (line_fill > 0) ? line_fill - 1 : 0;
        p = PARAM_POS;
        while (p < stop && byte_at(p) != 8'h00) p++;
        stop = p;
        if (stop <= PARAM_POS)
        begin
            replies_due.push_back(r);
            return;
        end
        for (p = PARAM_POS; p < stop; p++)
        begin
            r.param_byte  = byte_at(p);
            r.param_valid = 1'b1;
            r.last        = (p + 1 == stop);
            replies_due.push_back(r);
        end
    endtask

    // Works out what one accepted transaction makes the parser owe.
    task automatic predict_parse(input item_t it);
        if (it.action == ACT_TICK)
        begin
            // Ticks only count while a line is open.
            if (!line_open) return;
            if (line_ticks < ELAPSED_MAX) line_ticks++;
            if (line_ticks > {1'b0, parser_cfg.timeout_ticks})
            begin
                clear_line();
                owe_status(ST_SERIAL);
            end
            return;
        end
        if (!line_open)
        begin
            line_open  = 1'b1;
            line_ticks = '0;
            line_fill  = 0;
        end
        if (line_fill < LINE_BYTES) line_bytes[line_fill] = it.rx_byte;
        line_fill++;
        if (it.rx_byte == NEWLINE_BYTE)
        begin
            owe_line_replies();
            clear_line();
        end
        else if (line_fill >= LINE_BYTES)
        begin
            // The buffer filled without a newline.
            clear_line();
            owe_status(ST_SERIAL);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver and monitor.
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // The driver moves on only after the current transaction went through,
    // so valid never drops and the payload never changes while it waits.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_gap   <= 0;
        end
        else if (!item_valid || item_taken)
        begin
            if (send_gap > 0)
            begin
                item_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end
            else if (items_to_send.size() != 0)
            begin
                item       <= items_to_send.pop_front();
                item_valid <= 1'b1;
                send_gap   <= pick_gap();
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // The receiver stalls at random. Once, after a few replies, it holds off
    // for a long stretch so that the parser backs up and closes its input.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_gap     <= 0;
            hold_left    <= 0;
        end
        else if (!long_hold_done && replies_seen >= HOLD_AFTER)
        begin
            long_hold_done <= 1'b1;
            hold_left      <= HOLD_CYCLES;
            result_ready   <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap     <= recv_gap - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
            recv_gap     <= pick_gap();
        end
    end

    // Both channels are sampled at the rising edge. An input transaction is
    // predicted before the reply check; a reply in the same cycle always
    // belongs to an earlier transaction, and it sits at the front of the queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_taken <= 1'b0;
        end
        else
        begin
            item_taken <= item_valid && item_ready;
            if (item_valid && item_ready)
            begin
                predict_parse(item);
                accepted_count++;
            end
            if (result_valid && result_ready)
            begin
                replies_seen++;
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected reply status=%0d slot=%0d code=%02h id=%04h",
                             $time, result.status, result.command_slot,
                             result.command_code, result.request_id);
                    mismatch_count++;
                end
                else if (result !== replies_due[0])
                begin
                    $display({"%0t: reply differs: expected status=%0d slot=%0d code=%02h",
                              " id=%04h param=%02h pv=%0b last=%0b, actual status=%0d",
                              " slot=%0d code=%02h id=%04h param=%02h pv=%0b last=%0b"},
                             $time, replies_due[0].status, replies_due[0].command_slot,
                             replies_due[0].command_code, replies_due[0].request_id,
                             replies_due[0].param_byte, replies_due[0].param_valid,
                             replies_due[0].last, result.status, result.command_slot,
                             result.command_code, result.request_id, result.param_byte,
                             result.param_valid, result.last);
                    mismatch_count++;
                    void'(replies_due.pop_front());
                end
                else
                begin
                    void'(replies_due.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    task automatic send(input logic act, input logic [7:0] b);
        item_t it;
        it.action  = act;
        it.rx_byte = b;
        items_to_send.push_back(it);
        queued_count++;
        useful_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send(ACT_BYTE, s[i]);
    endtask

    // A line byte, sometimes preceded by a tick that lands mid-line.
    task automatic send_line_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < tick_pct) send(ACT_TICK, $urandom);
        send(ACT_BYTE, b);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 10) return 8'h30 + v;
        return (upper ? 8'h41 : 8'h61) + v - 10;
    endfunction

    function automatic logic [7:0] non_newline();
        logic [7:0] b;
        b = $urandom;
        if (b == NEWLINE_BYTE) b = ~b;
        return b;
    endfunction

    // A command line in the current format. The code is usually one from the
    // table. A broken line gets a wrong start character or separator. A
    // negative parameter count picks one at random, mostly short.
    task automatic send_command_line(input bit broken, input int nparams);
        logic [7:0]  hdr [PARAM_POS];
        logic [7:0]  code;
        logic [15:0] id;
        int          slots, pos, r;
        slots = (parser_cfg.command_count > TABLE_SLOTS) ? TABLE_SLOTS
                                                         : parser_cfg.command_count;
        if (slots != 0 && $urandom_range(0, 99) < 70)
            code = parser_cfg.command_codes[8*$urandom_range(0, slots - 1) +: 8];
        else
            code = $urandom;
        id = $urandom;
        hdr[0] = parser_cfg.start_char;
        hdr[1] = hex_char(code[7:4], $urandom_range(0, 1));
        hdr[2] = hex_char(code[3:0], $urandom_range(0, 1));
        hdr[ID_SEP_POS] = parser_cfg.id_separator;
        for (int i = 0; i < ID_DIGITS; i++)
            hdr[ID_SEP_POS + 1 + i] = hex_char(id[15 - 4*i -: 4], $urandom_range(0, 1));
        hdr[PARAM_SEP_POS] = parser_cfg.param_separator;
        // Now and then a stray byte inside the digits ends decoding early.
        if ($urandom_range(0, 99) < 10)
            hdr[$urandom_range(1, PARAM_SEP_POS - 1)] = $urandom;
        if (broken)
        begin
            case ($urandom_range(0, 2))
                0:       pos = 0;
                1:       pos = ID_SEP_POS;
                default: pos = PARAM_SEP_POS;
            endcase
            hdr[pos] = hdr[pos] ^ 8'($urandom_range(1, 255));
        end
        if (nparams < 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)      nparams = 0;
            else if (r < 90) nparams = $urandom_range(1, 6);
            else             nparams = $urandom_range(7, LINE_BYTES - PARAM_POS - 1);
        end
        for (int i = 0; i < PARAM_POS; i++) send_line_byte(hdr[i]);
        for (int i = 0; i < nparams; i++)
            send_line_byte(($urandom_range(0, 99) < 5) ? 8'h00 : non_newline());
        send_line_byte(NEWLINE_BYTE);
    endtask

    // A few bytes and then ticks: one past the limit, or exactly up to it
    // followed by a newline. With a very long limit only a few ticks are sent.
    task automatic send_timeout_line();
        repeat ($urandom_range(1, 5)) send(ACT_BYTE, non_newline());
        if (parser_cfg.timeout_ticks > 40)
        begin
            repeat (3) send(ACT_TICK, $urandom);
            send(ACT_BYTE, NEWLINE_BYTE);
        end
        else if ($urandom_range(0, 1))
        begin
            repeat (parser_cfg.timeout_ticks + 1) send(ACT_TICK, $urandom);
        end
        else
        begin
            repeat (parser_cfg.timeout_ticks) send(ACT_TICK, $urandom);
            send(ACT_BYTE, NEWLINE_BYTE);
        end
    endtask

    // A line that fills the buffer without a newline.
    task automatic send_long_line();
        repeat (LINE_BYTES) send(ACT_BYTE, non_newline());
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12)) send($urandom_range(0, 1), $urandom);
        send(ACT_BYTE, NEWLINE_BYTE);
    endtask

    // Waits until every transaction went through and every reply came out.
    // A line left open is closed with a newline so that the next register
    // write finds the parser idle.
    task automatic drain();
        forever
        begin
            do @(negedge clk);
            while (accepted_count != queued_count || replies_due.size() != 0);
            if (!line_open) break;
            send(ACT_BYTE, NEWLINE_BYTE);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_START_CHAR:      parser_cfg.start_char      = data[7:0];
            REG_ID_SEPARATOR:    parser_cfg.id_separator    = data[7:0];
            REG_PARAM_SEPARATOR: parser_cfg.param_separator = data[7:0];
            REG_TIMEOUT_TICKS:   parser_cfg.timeout_ticks   = data[15:0];
            REG_COMMAND_CODES:   parser_cfg.command_codes   = data;
            REG_COMMAND_COUNT:   parser_cfg.command_count   = data[3:0];
            default:             ;
        endcase
    endtask

    // Random lines, mostly well formed, until the phase has its share of
    // transactions. Ticks between lines are ignored by the parser and do not
    // count toward the share.
    task automatic random_phase(input int share);
        int first, r;
        first = useful_items;
        while (useful_items - first < share)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                items_to_send.push_back('{action: ACT_TICK, rx_byte: 8'($urandom)});
                queued_count++;
            end
            r = $urandom_range(0, 99);
            if (r < 68)      send_command_line(1'b0, -1);
            else if (r < 78) send_command_line(1'b1, -1);
            else if (r < 87) send_timeout_line();
            else if (r < 91) send_long_line();
            else             send_noise();
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------

    initial begin
        parser_cfg.start_char      = START_CHAR_RST;
        parser_cfg.id_separator    = SEPARATOR_RST;
        parser_cfg.param_separator = SEPARATOR_RST;
        parser_cfg.timeout_ticks   = TIMEOUT_RST;
        parser_cfg.command_codes   = '0;
        parser_cfg.command_count   = '0;
        clear_line();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: a tick on an idle parser does nothing, and a lone
        // newline opens a line that fails the start character check.
        send(ACT_TICK, 8'h00);
        send(ACT_BYTE, NEWLINE_BYTE);
        drain();

        // A table with a repeated code and the top slot filled, a count above
        // the table size, and no ticks allowed at all.
        write_reg(REG_COMMAND_CODES, 64'hFF00_1122_33A5_44A5);
        write_reg(REG_COMMAND_COUNT, 64'd15);
        write_reg(REG_TIMEOUT_TICKS, 64'd0);
        // Mixed-case digits; parameters stop at the zero byte; the repeated
        // code resolves to the lower slot.
        send_text("$A5:0a0B:");
        send(ACT_BYTE, 8'h01);
        send(ACT_BYTE, 8'hFF);
        send(ACT_BYTE, 8'h00);
        send_text("Z\n");
        // Top slot only reachable through the clamped count; the id stops at
        // a non-hex character; no parameters at all.
        send_text("$Ff:G123:\n");
        // One tick after the first byte is already too many.
        send_text("$");
        send(ACT_TICK, 8'hFF);
        drain();

        // Default format, a short timeout and a random table. One line fills
        // the buffer and one uses every byte of it up to the newline.
        write_reg(REG_TIMEOUT_TICKS, 64'd12);
        write_reg(REG_COMMAND_CODES, {$urandom, $urandom});
        write_reg(REG_COMMAND_COUNT, $urandom_range(1, 8));
        tick_pct = 8;
        send_long_line();
        send_command_line(1'b0, LINE_BYTES - PARAM_POS - 1);
        random_phase(40);

        // Extreme characters, the longest timeout, a full table of 0xFF codes,
        // and no idling on either side.
        write_reg(REG_START_CHAR, 64'hFF);
        write_reg(REG_ID_SEPARATOR, 64'h00);
        write_reg(REG_PARAM_SEPARATOR, 64'hFF);
        write_reg(REG_TIMEOUT_TICKS, 64'hFFFF);
        write_reg(REG_COMMAND_CODES, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_COMMAND_COUNT, 64'd8);
        gaps_on  = 1'b0;
        tick_pct = 15;
        random_phase(35);

        // Zero start character and parameter separator, a random id separator, a zero
        // timeout, a random table size and a last write to an index with no register.
        write_reg(REG_START_CHAR, 64'h00);
        write_reg(REG_ID_SEPARATOR, $urandom_range(0, 255));
        write_reg(REG_PARAM_SEPARATOR, 64'h00);
        write_reg(REG_TIMEOUT_TICKS, 64'd0);
        write_reg(REG_COMMAND_CODES, {$urandom, $urandom});
        write_reg(REG_COMMAND_COUNT, $urandom_range(0, 15));
        write_reg(REG_UNUSED, '1);
        gaps_on  = 1'b1;
        tick_pct = 2;
        random_phase(35);

        if (replies_due.size() != 0)
        begin
            $display("%0t: %0d replies never arrived", $time, replies_due.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("%0t: timed out", $time);
        $display("Mismatches found");
        $finish;
    end

endmodule
